// ===== design/tdm_pkg.sv =====
// ---------------------------------------------------------------------------
// tdm_pkg
// Shared types and constants for the tile map deduplication block.
// ---------------------------------------------------------------------------
package tdm_pkg;

    localparam int TILE_ROWS = 8;
    localparam int ROW_W     = 16;
    localparam int ROW_IDX_W = 3;
    localparam int TILE_W    = TILE_ROWS * ROW_W;
    localparam int IDX_OUT_W = 8;
    localparam int CNT_OUT_W = 9;

    localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(TILE_ROWS - 1);

    typedef struct packed {
        logic [ROW_W-1:0] row_pixels;
        logic             clear_table;
    } tdm_in_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] tile_index;
        logic                 is_new;
        logic                 table_overflow;
        logic [CNT_OUT_W-1:0] unique_count;
    } tdm_out_t;

    typedef enum logic [1:0] {
        ST_GATHER,
        ST_SEARCH,
        ST_DONE
    } tdm_state_t;

endpackage

// ===== design/tile_dedup_map_builder.sv =====
// ---------------------------------------------------------------------------
// tile_dedup_map_builder
// Gathers 8x8 2-bit tiles row by row and maps each tile to a unique index.
// ---------------------------------------------------------------------------
// rows 0..6 of a tile are taken one per cycle and give no result
// after the last row the store is scanned one tile per cycle; the result
//   goes to the output register once a match is found or the scan ends
// input is held off during the scan, so the next tile waits for the result
// the single-port-read tile memory sets the scan rate
// reset (aresetn, synchronous) empties the table; store contents are not cleared
module tile_dedup_map_builder #(
    parameter int MAX_TILES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tdm_pkg::tdm_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tdm_pkg::tdm_out_t m_data
);
    import tdm_pkg::*;

    localparam int IDX_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
    localparam int CNT_W = $clog2(MAX_TILES + 1);
    localparam logic [31:0] MAX_WIDE = 32'(MAX_TILES);
    localparam logic [CNT_OUT_W-1:0] MAX_CNT_OUT = MAX_WIDE[CNT_OUT_W-1:0];

    logic              res_valid;
    logic              res_ready;
    tdm_out_t          res_data;
    logic              mem_wr_en;
    logic [IDX_W-1:0]  mem_wr_addr;
    logic [TILE_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IDX_W-1:0]  mem_rd_addr;
    logic [TILE_W-1:0] mem_rd_data;

    logic              m_valid_reg, m_valid_next;
    tdm_out_t          m_data_reg, m_data_next;

    tdm_ctrl #(
        .MAX_TILES (MAX_TILES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_data     (s_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_data    (res_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tdm_tile_mem #(
        .MAX_TILES (MAX_TILES),
        .IDX_W     (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register, refilled when empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                m_data_next = res_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_new_xor_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_new && m_data.table_overflow))
        else $error("result flags both new and overflow");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.table_overflow) |-> (m_data.unique_count == MAX_CNT_OUT))
        else $error("overflow reported with table not full");

    a_new_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_new)
            |-> (m_data.tile_index == IDX_OUT_W'(m_data.unique_count - 9'd1)))
        else $error("new tile index does not match count");

    a_no_input_while_result: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> !s_ready)
        else $error("input taken while result is pending");

endmodule

// ===== design/tdm_tile_mem.sv =====
// ---------------------------------------------------------------------------
// tdm_tile_mem
// Unique tile store: one whole tile per word, one write and one registered
// read port.
// ---------------------------------------------------------------------------
module tdm_tile_mem #(
    parameter int MAX_TILES = 256,
    parameter int IDX_W     = 8
) (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic [tdm_pkg::TILE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic [tdm_pkg::TILE_W-1:0] rd_data
);
    import tdm_pkg::*;

    logic [TILE_W-1:0] mem [MAX_TILES];
    logic [TILE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/tdm_ctrl.sv =====
// ---------------------------------------------------------------------------
// tdm_ctrl
// Row gathering, linear search over the tile store and append/overflow
// decision.
// ---------------------------------------------------------------------------
module tdm_ctrl #(
    parameter int MAX_TILES = 256,
    parameter int IDX_W     = 8,
    parameter int CNT_W     = 9
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tdm_pkg::tdm_in_t           in_data,
    output logic                       res_valid,
    input  logic                       res_ready,
    output tdm_pkg::tdm_out_t          res_data,
    output logic                       mem_wr_en,
    output logic [IDX_W-1:0]           mem_wr_addr,
    output logic [tdm_pkg::TILE_W-1:0] mem_wr_data,
    output logic                       mem_rd_en,
    output logic [IDX_W-1:0]           mem_rd_addr,
    input  logic [tdm_pkg::TILE_W-1:0] mem_rd_data
);
    import tdm_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TILES);

    tdm_state_t                    state_reg, state_next;
    logic [ROW_IDX_W-1:0]          row_cnt_reg, row_cnt_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              scan_reg, scan_next;
    logic [CNT_W-1:0]              cmp_slot_reg, cmp_slot_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [TILE_ROWS-1:0][ROW_W-1:0] pending_reg, pending_next;
    tdm_out_t                      res_reg, res_next;

    logic                 accept;
    logic [ROW_IDX_W-1:0] row_idx;
    logic                 issue;
    logic                 hit;
    logic                 done;
    logic [31:0]          idx_wide;
    logic [31:0]          cnt_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_GATHER;
            row_cnt_reg <= '0;
            count_reg   <= '0;
            scan_reg    <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            rd_vld_reg  <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_slot_reg <= cmp_slot_next;
        pending_reg  <= pending_next;
        res_reg      <= res_next;
    end

    assign accept  = in_valid && in_ready;
    assign row_idx = in_data.clear_table ? '0 : row_cnt_reg;

    assign issue = (state_reg == ST_SEARCH) && (scan_reg < count_reg);
    assign hit   = rd_vld_reg && (mem_rd_data == pending_reg);
    assign done  = hit || (!issue && !rd_vld_reg);

    assign mem_rd_en   = issue;
    assign mem_rd_addr = scan_reg[IDX_W-1:0];
    assign mem_wr_addr = count_reg[IDX_W-1:0];
    assign mem_wr_data = pending_reg;

    always_comb begin
        state_next    = state_reg;
        row_cnt_next  = row_cnt_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        cmp_slot_next = cmp_slot_reg;
        rd_vld_next   = 1'b0;
        pending_next  = pending_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        mem_wr_en     = 1'b0;
        idx_wide      = '0;
        cnt_wide      = '0;

        case (state_reg)
            ST_GATHER: begin
                in_ready = 1'b1;
                if (accept) begin
                    pending_next[row_idx] = in_data.row_pixels;
                    if (in_data.clear_table) begin
                        count_next = '0;
                    end
                    if (row_idx == LAST_ROW) begin
                        row_cnt_next = '0;
                        scan_next    = '0;
                        state_next   = ST_SEARCH;
                    end else begin
                        row_cnt_next = row_idx + ROW_IDX_W'(1);
                    end
                end
            end

            ST_SEARCH: begin
                // one read in flight, compare is made on the registered read data
                if (issue) begin
                    scan_next     = scan_reg + CNT_W'(1);
                    rd_vld_next   = 1'b1;
                    cmp_slot_next = scan_reg;
                end
                if (done) begin
                    rd_vld_next = 1'b0;
                    state_next  = ST_DONE;
                    res_next    = '0;
                    if (hit) begin
                        idx_wide = 32'(cmp_slot_reg);
                        cnt_wide = 32'(count_reg);
                    end else if (count_reg < MAX_CNT) begin
                        mem_wr_en         = 1'b1;
                        idx_wide          = 32'(count_reg);
                        cnt_wide          = 32'(count_reg) + 32'd1;
                        count_next        = count_reg + CNT_W'(1);
                        res_next.is_new   = 1'b1;
                    end else begin
                        cnt_wide                = 32'(count_reg);
                        res_next.table_overflow = 1'b1;
                    end
                    res_next.tile_index   = idx_wide[IDX_OUT_W-1:0];
                    res_next.unique_count = cnt_wide[CNT_OUT_W-1:0];
                end
            end

            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_GATHER;
                end
            end

            default: begin
                state_next = ST_GATHER;
            end
        endcase
    end

    assign res_data = res_reg;

endmodule
